// ===== rtl/ffha_pkg.sv =====
// ffha_pkg: shared types and constants of the first-fit heap allocator
// holds the transaction structs, header layout, status and function codes
// no dependencies
package ffha_pkg;

  // header layout and allocation granules
  localparam int HEADER_BYTES = 4;
  localparam int ALIGN_BYTES  = 4;
  localparam int SIZE_W       = 15;
  localparam int HDR_W        = 16;
  // heap offsets can run past the heap while walking, so keep headroom
  localparam int OFF_W        = 18;

  // function codes
  localparam logic [1:0] FUNC_ALLOC   = 2'd0;
  localparam logic [1:0] FUNC_RELEASE = 2'd1;
  localparam logic [1:0] FUNC_RESIZE  = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_NOSPACE = 2'd2;
  localparam logic [1:0] ST_MOVE    = 2'd3;

  // configuration register indexes
  localparam logic CFG_HEAP_BASE  = 1'b0;
  localparam logic CFG_HEAP_LIMIT = 1'b1;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] request_size;
    logic [31:0] block_address;
  } ffha_in_t;

  typedef struct packed {
    logic [31:0]       result_address;
    logic [1:0]        status;
    logic [SIZE_W-1:0] old_size;
  } ffha_out_t;

  // a header at off fits when the whole header lies inside the usable bytes
  function automatic logic fits(input logic [OFF_W-1:0] off, input logic [OFF_W-1:0] lim);
    return ({1'b0, off} + (OFF_W+1)'(HEADER_BYTES)) <= {1'b0, lim};
  endfunction

endpackage

// ===== rtl/ffha_ram.sv =====
// ffha_ram: generic simple dual-port ram, one write and one registered read port
// depends on nothing
module ffha_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/first_fit_heap_allocator_unit.sv =====
// first_fit_heap_allocator_unit: first-fit boundary-tag heap manager
// depends on ffha_pkg and ffha_ram (header memory)
//
// Usage: a command transaction is taken on a clock edge with start high and
// busy low; in_data carries func, request_size and block_address. Exactly
// one result per command appears on out_data for one cycle with out_valid
// high; the receiver cannot stall it.
// The cfg port (cfg_we, cfg_index, cfg_wdata) writes heap_base (index 0) or
// heap_limit (index 1); write it only while busy is low.
// Every header visit is one read of the header memory.
// After the accepting edge busy stays high while headers are read (used
// blocks skipped, free blocks joined, first-free pointer advanced) and for
// any second header write or the step to the first-free walk; a refused or
// trivial command keeps busy low. The result is on out_data in the cycle in
// which busy falls, and the next command can be taken in that same cycle,
// so the time per command grows with heap fragmentation; one command at a
// time.
// Reset: rst_n clears the control state and then a clearing pass writes zero
// to every header entry, with busy high; configuration writes are taken
// during the pass.
module first_fit_heap_allocator_unit #(
  parameter int HEAP_BYTES = 32768
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ffha_pkg::ffha_in_t  in_data,
  output logic              out_valid,
  output ffha_pkg::ffha_out_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_wdata
);

  localparam int AW = $clog2(HEAP_BYTES);
  localparam int OW = ffha_pkg::OFF_W;
  localparam int SW = ffha_pkg::SIZE_W;
  localparam logic [OW-1:0] HDR   = OW'(ffha_pkg::HEADER_BYTES);
  localparam logic [OW-1:0] ALGN  = OW'(ffha_pkg::ALIGN_BYTES);
  localparam logic [OW-1:0] SMAX  = OW'(2**SW - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_A_LOOK, S_A_JOIN, S_A_SPLIT, S_A_TAKE, S_A_FIN, S_A_ADV,
    S_R_HDR, S_R_WALK, S_Z_HDR, S_Z_NEXT, S_Z_END, S_Z_CUT
  } state_t;

  state_t state_r, state_nxt;
  logic [OW-1:0] h_r, h_nxt, c_r, c_nxt, tot_r, tot_nxt, s_r, s_nxt;
  logic [OW-1:0] b_r, b_nxt, ff_r, ff_nxt;
  logic [SW-1:0] cur_r, cur_nxt, old_r, old_nxt, v_r, v_nxt;
  logic [31:0]   base_r;
  logic [15:0]   limit_r;
  logic          out_valid_r, out_valid_nxt;
  ffha_pkg::ffha_out_t out_r, out_nxt;
  logic          clearing_r;
  logic [AW-1:0] clr_cnt_r;
  logic          fits_q_r;

  logic [OW-1:0] lim, rd_off, wa;
  logic [15:0]   wd, ram_q, hdr, ram_wd;
  logic          we, ram_we;
  logic [AW-1:0] ram_wa;
  logic [SW-1:0] hsz;
  logic          hused;
  logic [OW-1:0] te_nx, p, rs;
  logic          te_ok;
  logic [31:0]   rel, b32;
  logic          loc_ok;
  logic [OW-1:0] t2;

  // usable heap bytes
  assign lim = (OW'(limit_r) < OW'(HEAP_BYTES)) ? OW'(limit_r) : OW'(HEAP_BYTES);

  // header memory
  assign ram_we = clearing_r | (we & ffha_pkg::fits(wa, lim));
  assign ram_wa = clearing_r ? clr_cnt_r : wa[AW-1:0];
  assign ram_wd = clearing_r ? '0 : wd;

  ffha_ram #(.WIDTH(ffha_pkg::HDR_W), .DEPTH(HEAP_BYTES)) u_hdr_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_wa),
    .wdata (ram_wd),
    .raddr (rd_off[AW-1:0]),
    .rdata (ram_q)
  );

  // header read back, outside the heap reads as the end marker
  assign hdr   = fits_q_r ? ram_q : '0;
  assign hsz   = hdr[SW-1:0];
  assign hused = hdr[15];

  // shared address arithmetic
  assign te_nx = h_r + HDR + s_r;
  assign te_ok = ffha_pkg::fits(h_r, lim) && ffha_pkg::fits(te_nx, lim);
  assign p     = b_r + HDR;
  assign t2    = tot_r + OW'(hsz) + HDR;
  assign rs    = (in_data.request_size == 16'd0) ? ALGN :
                 ((OW'(in_data.request_size) + ALGN - OW'(1)) & ~(ALGN - OW'(1)));
  assign rel    = in_data.block_address - base_r;
  assign b32    = rel - 32'(ffha_pkg::HEADER_BYTES);
  assign loc_ok = (rel >= 32'(ffha_pkg::HEADER_BYTES)) && (b32[31:OW] == '0) &&
                  ffha_pkg::fits(b32[OW-1:0], lim);

  assign busy      = clearing_r | (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // command sequencer
  always_comb begin
    state_nxt     = state_r;
    h_nxt         = h_r;
    c_nxt         = c_r;
    tot_nxt       = tot_r;
    s_nxt         = s_r;
    b_nxt         = b_r;
    ff_nxt        = ff_r;
    cur_nxt       = cur_r;
    old_nxt       = old_r;
    v_nxt         = v_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    rd_off        = h_r;
    we            = 1'b0;
    wa            = h_r;
    wd            = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start && !clearing_r) begin
          s_nxt   = rs;
          h_nxt   = ff_r;
          rd_off  = ff_r;
          b_nxt   = b32[OW-1:0];
          old_nxt = '0;
          out_nxt = '0;
          unique case (in_data.func)
            ffha_pkg::FUNC_ALLOC: begin
              if (in_data.request_size[15]) begin
                out_nxt.status = ffha_pkg::ST_REFUSED;
                out_valid_nxt  = 1'b1;
              end else if (rs > SMAX) begin
                out_nxt.status = ffha_pkg::ST_NOSPACE;
                out_valid_nxt  = 1'b1;
              end else begin
                state_nxt = S_A_LOOK;
              end
            end
            ffha_pkg::FUNC_RELEASE: begin
              if (in_data.block_address != 32'd0 && loc_ok) begin
                rd_off    = b32[OW-1:0];
                state_nxt = S_R_HDR;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            ffha_pkg::FUNC_RESIZE: begin
              if (in_data.request_size[15]) begin
                out_nxt.status = ffha_pkg::ST_REFUSED;
                out_valid_nxt  = 1'b1;
              end else if (in_data.block_address == 32'd0) begin
                if (rs > SMAX) begin
                  out_nxt.status = ffha_pkg::ST_NOSPACE;
                  out_valid_nxt  = 1'b1;
                end else begin
                  state_nxt = S_A_LOOK;
                end
              end else if (!loc_ok) begin
                out_nxt.status = ffha_pkg::ST_NOSPACE;
                out_valid_nxt  = 1'b1;
              end else begin
                rd_off    = b32[OW-1:0];
                state_nxt = S_Z_HDR;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      // look at the header at h
      S_A_LOOK: begin
        if (hdr == '0) begin
          if (te_ok) begin
            we        = 1'b1;
            wa        = h_r;
            wd        = 16'h8000 | s_r[15:0];
            state_nxt = S_A_TAKE;
          end else begin
            out_nxt       = '0;
            out_nxt.status = ffha_pkg::ST_NOSPACE;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else if (hused) begin
          h_nxt  = h_r + HDR + OW'(hsz);
          rd_off = h_nxt;
        end else if (OW'(hsz) < s_r) begin
          c_nxt     = h_r + HDR + OW'(hsz);
          tot_nxt   = OW'(hsz);
          rd_off    = c_nxt;
          state_nxt = S_A_JOIN;
        end else if (OW'(hsz) > s_r + HDR + ALGN) begin
          we        = 1'b1;
          wa        = h_r + HDR + s_r;
          wd        = 16'(OW'(hsz) - s_r - HDR);
          state_nxt = S_A_SPLIT;
        end else begin
          we        = 1'b1;
          wa        = h_r;
          wd        = {1'b1, hsz};
          state_nxt = S_A_FIN;
        end
      end
      // join following free blocks onto a too-small free block
      S_A_JOIN: begin
        if (hused) begin
          h_nxt     = c_r;
          rd_off    = c_r;
          state_nxt = S_A_LOOK;
        end else if (hdr == '0) begin
          if (te_ok) begin
            we        = 1'b1;
            wa        = h_r;
            wd        = 16'h8000 | s_r[15:0];
            state_nxt = S_A_TAKE;
          end else begin
            out_nxt       = '0;
            out_nxt.status = ffha_pkg::ST_NOSPACE;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else if (t2 < s_r) begin
          tot_nxt = t2;
          c_nxt   = c_r + HDR + OW'(hsz);
          rd_off  = c_nxt;
        end else begin
          we        = 1'b1;
          wa        = h_r;
          wd        = {1'b1, t2[SW-1:0]};
          state_nxt = S_A_FIN;
        end
      end
      S_A_SPLIT: begin
        we        = 1'b1;
        wa        = h_r;
        wd        = 16'h8000 | s_r[15:0];
        state_nxt = S_A_FIN;
      end
      // new end marker after a block taken at the end
      S_A_TAKE: begin
        we    = 1'b1;
        wa    = te_nx;
        wd    = '0;
        if (h_r == ff_r) begin
          ff_nxt = te_nx;
        end
        out_nxt                = '0;
        out_nxt.result_address = base_r + 32'(h_r) + 32'(ffha_pkg::HEADER_BYTES);
        out_valid_nxt          = 1'b1;
        state_nxt              = S_IDLE;
      end
      S_A_FIN: begin
        if (h_r == ff_r) begin
          rd_off    = ff_r;
          state_nxt = S_A_ADV;
        end else begin
          out_nxt                = '0;
          out_nxt.result_address = base_r + 32'(h_r) + 32'(ffha_pkg::HEADER_BYTES);
          out_valid_nxt          = 1'b1;
          state_nxt              = S_IDLE;
        end
      end
      // move the first-free pointer past used blocks
      S_A_ADV: begin
        if (hused && ffha_pkg::fits(ff_r + HDR + OW'(hsz), lim)) begin
          ff_nxt = ff_r + HDR + OW'(hsz);
          rd_off = ff_nxt;
        end else begin
          out_nxt                = '0;
          out_nxt.result_address = base_r + 32'(h_r) + 32'(ffha_pkg::HEADER_BYTES);
          out_valid_nxt          = 1'b1;
          state_nxt              = S_IDLE;
        end
      end
      // release: read the block's own header
      S_R_HDR: begin
        old_nxt = hsz;
        v_nxt   = hsz;
        c_nxt   = b_r + HDR + OW'(hsz);
        rd_off  = c_nxt;
        if (b_r < ff_r) begin
          ff_nxt = b_r;
        end
        state_nxt = S_R_WALK;
      end
      // release: merge forward until a used block or the end marker
      S_R_WALK: begin
        if (hused || hdr == '0) begin
          we                = 1'b1;
          wa                = b_r;
          wd                = hused ? {1'b0, v_r} : '0;
          out_nxt           = '0;
          out_nxt.old_size  = old_r;
          out_valid_nxt     = 1'b1;
          state_nxt         = S_IDLE;
        end else begin
          v_nxt  = v_r + hsz + SW'(ffha_pkg::HEADER_BYTES);
          c_nxt  = c_r + HDR + OW'(hsz);
          rd_off = c_nxt;
        end
      end
      // resize: read the block's own header
      S_Z_HDR: begin
        cur_nxt = hsz;
        old_nxt = hsz;
        if (s_r == OW'(hsz)) begin
          out_nxt                = '0;
          out_nxt.result_address = base_r + 32'(p);
          out_nxt.old_size       = hsz;
          out_valid_nxt          = 1'b1;
          state_nxt              = S_IDLE;
        end else begin
          rd_off    = p + OW'(hsz);
          state_nxt = S_Z_NEXT;
        end
      end
      // resize: last block grows or shrinks, otherwise truncate or move
      S_Z_NEXT: begin
        out_nxt          = '0;
        out_nxt.old_size = old_r;
        if (hdr == '0) begin
          if (s_r > SMAX || !ffha_pkg::fits(p + s_r, lim)) begin
            out_nxt.status = ffha_pkg::ST_NOSPACE;
            out_valid_nxt  = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            if (p + OW'(cur_r) == ff_r) begin
              ff_nxt = p + s_r;
            end
            we        = 1'b1;
            wa        = b_r;
            wd        = 16'h8000 | s_r[15:0];
            state_nxt = S_Z_END;
          end
        end else if (s_r + HDR < OW'(cur_r)) begin
          we        = 1'b1;
          wa        = p + s_r;
          wd        = 16'(OW'(cur_r) - s_r - HDR);
          state_nxt = S_Z_CUT;
        end else begin
          out_nxt.status = ffha_pkg::ST_MOVE;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_Z_END: begin
        we                     = 1'b1;
        wa                     = p + s_r;
        wd                     = '0;
        out_nxt                = '0;
        out_nxt.result_address = base_r + 32'(p);
        out_nxt.old_size       = old_r;
        out_valid_nxt          = 1'b1;
        state_nxt              = S_IDLE;
      end
      S_Z_CUT: begin
        we                     = 1'b1;
        wa                     = b_r;
        wd                     = 16'h8000 | s_r[15:0];
        out_nxt                = '0;
        out_nxt.result_address = base_r + 32'(p);
        out_nxt.old_size       = old_r;
        out_valid_nxt          = 1'b1;
        state_nxt              = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state, registered outputs and working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ff_r        <= '0;
      out_valid_r <= 1'b0;
      clearing_r  <= 1'b1;
      clr_cnt_r   <= '0;
      base_r      <= '0;
      limit_r     <= 16'h8000;
    end else begin
      state_r     <= state_nxt;
      ff_r        <= ff_nxt;
      out_valid_r <= out_valid_nxt;
      if (clearing_r) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(HEAP_BYTES - 1)) begin
          clearing_r <= 1'b0;
        end
      end
      if (cfg_we) begin
        if (cfg_index == ffha_pkg::CFG_HEAP_BASE) begin
          base_r <= cfg_wdata;
        end else begin
          limit_r <= cfg_wdata[15:0];
        end
      end
    end
    h_r      <= h_nxt;
    c_r      <= c_nxt;
    tot_r    <= tot_nxt;
    s_r      <= s_nxt;
    b_r      <= b_nxt;
    cur_r    <= cur_nxt;
    old_r    <= old_nxt;
    v_r      <= v_nxt;
    out_r    <= out_nxt;
    fits_q_r <= ffha_pkg::fits(rd_off, lim);
  end

endmodule
